// ===== rtl/tsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrs_pkg
// Shared types and codes for the temperature reading supervisor.
// ----------------------------------------------------------------------------
package tsrs_pkg;

  // read attempt kinds carried in the mode field
  typedef enum logic [2:0] {
    MODE_SAMPLE   = 3'd0,
    MODE_TIMEOUT  = 3'd1,
    MODE_BUS_ERR  = 3'd2,
    MODE_REC_OK   = 3'd3,
    MODE_REC_FAIL = 3'd4
  } mode_t;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WINDOW  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_BUS_ERR = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  // register indexes (byte address 4*i)
  localparam logic [1:0] REG_VALID_MIN  = 2'd0;
  localparam logic [1:0] REG_VALID_MAX  = 2'd1;
  localparam logic [1:0] REG_FAIL_LIMIT = 2'd2;

  localparam int unsigned TenthsW  = 13;
  localparam int unsigned PaddrW   = 4;

  localparam logic signed [TenthsW-1:0] VALID_MIN_RST  = -13'sd400;
  localparam logic signed [TenthsW-1:0] VALID_MAX_RST  = 13'sd1250;
  localparam logic [7:0]                FAIL_LIMIT_RST = 8'd3;
  localparam logic signed [15:0]        TEMP_INVALID   = 16'sh8000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] raw_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] temp_tenths;
    logic               in_fault;
    logic [7:0]         fail_streak;
    logic [15:0]        fault_total;
    logic [1:0]         active_code;
    logic [1:0]         last_code;
  } out_item_t;

  // result of the sample conversion
  typedef struct packed {
    logic signed [TenthsW-1:0] tenths;
    logic                      in_window;
  } conv_res_t;

endpackage

// ===== rtl/tsrs_convert.sv =====
// ----------------------------------------------------------------------------
// tsrs_convert
// Q4 sensor word to tenths of a degree with window check.
// ----------------------------------------------------------------------------
module tsrs_convert (
  input  logic [15:0]                        raw_word,
  input  logic signed [tsrs_pkg::TenthsW-1:0] valid_min,
  input  logic signed [tsrs_pkg::TenthsW-1:0] valid_max,
  output tsrs_pkg::conv_res_t                 res
);
  import tsrs_pkg::*;

  logic                neg;
  logic [12:0]         mag;
  logic [16:0]         scaled;
  logic [11:0]         rounded;
  logic signed [12:0]  tenths;

  // alert flags in bits 15..13 are dropped
  assign neg = raw_word[12];
  // 13-bit negate; -4096 wraps to an unsigned 4096 which is what we want
  assign mag = neg ? 13'(-raw_word[12:0]) : raw_word[12:0];
  // round half away from zero: (|q4| * 10 + 8) >> 4
  assign scaled  = 17'(mag) * 17'd10 + 17'd8;
  assign rounded = scaled[15:4];
  assign tenths  = neg ? 13'(-{1'b0, rounded}) : {1'b0, rounded};

  assign res.tenths    = tenths;
  assign res.in_window = (tenths >= valid_min) && (tenths <= valid_max);

endmodule

// ===== rtl/temp_sensor_reading_supervisor.sv =====
// ----------------------------------------------------------------------------
// temp_sensor_reading_supervisor
// Converts sensor words, tracks failure streaks and latches a fault state.
// ----------------------------------------------------------------------------
// Results land in the result register, or in the skid stage while the output
// stalls. Throughput: one transaction per cycle while in_stall is low; the state
// update for an item is a single registered pass, and a one-entry skid stage
// behind the result register takes one more transaction while the output stalls.
// Reset (synchronous, rst_n low): state and registers to their defaults,
// result and skid stages empty.
module temp_sensor_reading_supervisor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tsrs_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tsrs_pkg::out_item_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tsrs_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tsrs_pkg::*;

  // configuration
  logic signed [TenthsW-1:0] valid_min_r, valid_max_r;
  logic [7:0]                fail_limit_r;
  logic                      cfg_wr;
  logic [1:0]                reg_idx;

  // supervisor state
  logic               fault_r, fault_nxt;
  logic [7:0]         streak_r, streak_nxt;
  logic [15:0]        fault_total_r, fault_total_nxt;
  logic signed [15:0] last_temp_r, last_temp_nxt;
  logic [1:0]         active_code_r, active_code_nxt;
  logic [1:0]         last_code_r, last_code_nxt;

  logic               accept;
  logic [2:0]         status;
  logic               fail;
  logic [1:0]         fail_code;
  logic [7:0]         streak_inc;
  conv_res_t          conv;
  out_item_t          result;

  // output and skid stages
  logic       out_valid_r, skid_valid_r;
  out_item_t  out_data_r, skid_data_r;
  logic       out_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_min_r  <= VALID_MIN_RST;
      valid_max_r  <= VALID_MAX_RST;
      fail_limit_r <= FAIL_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_VALID_MIN:  valid_min_r  <= pwdata[TenthsW-1:0];
        REG_VALID_MAX:  valid_max_r  <= pwdata[TenthsW-1:0];
        REG_FAIL_LIMIT: fail_limit_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VALID_MIN:  prdata = 32'(valid_min_r);
      REG_VALID_MAX:  prdata = 32'(valid_max_r);
      REG_FAIL_LIMIT: prdata = {24'd0, fail_limit_r};
      default:        prdata = 32'd0;
    endcase
  end

  tsrs_convert u_convert (
    .raw_word  (in_data.raw_word),
    .valid_min (valid_min_r),
    .valid_max (valid_max_r),
    .res       (conv)
  );

  // next supervisor state for the incoming transaction
  always_comb begin
    fault_nxt       = fault_r;
    streak_nxt      = streak_r;
    fault_total_nxt = fault_total_r;
    last_temp_nxt   = last_temp_r;
    active_code_nxt = active_code_r;
    last_code_nxt   = last_code_r;
    status          = ST_OK;
    fail            = 1'b0;
    fail_code       = ST_OK[1:0];
    streak_inc      = (streak_r == 8'hFF) ? streak_r : streak_r + 8'd1;

    if (fault_r && (in_data.mode == MODE_SAMPLE || in_data.mode == MODE_TIMEOUT ||
                    in_data.mode == MODE_BUS_ERR)) begin
      status = ST_REFUSED;
    end else begin
      case (in_data.mode)
        MODE_SAMPLE: begin
          if (!conv.in_window) begin
            status = ST_WINDOW;
            fail   = 1'b1;
          end else begin
            last_temp_nxt   = 16'(conv.tenths);
            streak_nxt      = 8'd0;
            active_code_nxt = ST_OK[1:0];
            fault_nxt       = 1'b0;
          end
        end
        MODE_TIMEOUT: begin
          status = ST_TIMEOUT;
          fail   = 1'b1;
        end
        MODE_BUS_ERR: begin
          status = ST_BUS_ERR;
          fail   = 1'b1;
        end
        MODE_REC_OK: begin
          streak_nxt = 8'd0;
          fault_nxt  = 1'b0;
        end
        MODE_REC_FAIL: status = ST_BUS_ERR;
        default: ;
      endcase
    end

    if (fail) begin
      fail_code     = status[1:0];
      last_temp_nxt = TEMP_INVALID;
      last_code_nxt = fail_code;
      streak_nxt    = streak_inc;
      if (streak_inc >= fail_limit_r) begin
        if (!fault_r && fault_total_r != 16'hFFFF) begin
          fault_total_nxt = fault_total_r + 16'd1;
        end
        fault_nxt       = 1'b1;
        active_code_nxt = fail_code;
      end else begin
        fault_nxt = 1'b0;
      end
    end
  end

  assign result.status      = status;
  assign result.temp_tenths = last_temp_nxt;
  assign result.in_fault    = fault_nxt;
  assign result.fail_streak = streak_nxt;
  assign result.fault_total = fault_total_nxt;
  assign result.active_code = active_code_nxt;
  assign result.last_code   = last_code_nxt;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid & ~skid_valid_r;
  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r       <= 1'b0;
      streak_r      <= 8'd0;
      fault_total_r <= 16'd0;
      last_temp_r   <= TEMP_INVALID;
      active_code_r <= ST_OK[1:0];
      last_code_r   <= ST_OK[1:0];
    end else if (accept) begin
      fault_r       <= fault_nxt;
      streak_r      <= streak_nxt;
      fault_total_r <= fault_total_nxt;
      last_temp_r   <= last_temp_nxt;
      active_code_r <= active_code_nxt;
      last_code_r   <= last_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= result;
      end
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a latched fault always follows at least one counted failure
  assert property (@(posedge clk) disable iff (!rst_n) fault_r |-> streak_r != 8'd0)
    else $error("fault latched with empty failure streak");

  // the skid entry only fills behind an occupied result register
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid stage holds data while result register is empty");

  // the fault counter moves only on entry into the fault state
  assert property (@(posedge clk) disable iff (!rst_n)
                   !$stable(fault_total_r) |-> $rose(fault_r))
    else $error("fault counter changed without fault entry");

endmodule
